### rtl/sfe_pkg.sv
`default_nettype none

package sfe_pkg;

   // Input item function codes.
   localparam logic [1:0] FUNC_SET_CHANNEL = 2'd0;
   localparam logic [1:0] FUNC_SET_FLAGS   = 2'd1;
   localparam logic [1:0] FUNC_FRAME       = 2'd2;

   // Frame layout.
   localparam logic [7:0] FRAME_START = 8'h0F;
   localparam logic [7:0] FRAME_END   = 8'h00;
   localparam int DATA_BYTES = 22;
   localparam int SLOT_COUNT = 16;
   localparam int CHAN_W     = 11;
   localparam int SLOT_W     = 4;
   localparam int NEXT_W     = 5;
   localparam int BYTE_CNT_W = 5;

   // Pending-bit accumulator: at most 7 leftover bits plus one 11-bit channel.
   localparam int ACC_W   = 19;
   localparam int NBITS_W = 5;

   // Reset contents of the channel store.
   localparam logic [CHAN_W-1:0] CENTRE_VALUE   = 11'd992;
   localparam logic [CHAN_W-1:0] THROTTLE_MIN   = 11'd128;
   localparam int                THROTTLE_INDEX = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_channel;
      logic write_flags;
      logic load_start;
      logic shift_data;
      logic load_flags;
      logic load_end;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/sfe_controller.sv
`default_nettype none

module sfe_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [1:0]  req_func,
   output logic             busy,
   output sfe_pkg::cmd_type cmd
);
   import sfe_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DATA  = 2'd1;
   localparam logic [1:0] ST_FLAGS = 2'd2;
   localparam logic [1:0] ST_END   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [BYTE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_func)
                  FUNC_SET_CHANNEL: cmd.write_channel = 1'b1;
                  FUNC_SET_FLAGS:   cmd.write_flags = 1'b1;
                  FUNC_FRAME: begin
                     cmd.load_start = 1'b1;
                     state_in       = ST_DATA;
                     count_in       = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_DATA: begin
            cmd.shift_data = 1'b1;
            if (count_ff == BYTE_CNT_W'(DATA_BYTES - 1)) begin
               state_in = ST_FLAGS;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_FLAGS: begin
            cmd.load_flags = 1'b1;
            state_in       = ST_END;
         end
         ST_END: begin
            cmd.load_end = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // The data phase never runs past the last data byte.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> (count_ff <= BYTE_CNT_W'(DATA_BYTES - 1)))
      else $error("data byte counter out of range");

   // Leaving the data phase happens only on the last data byte.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA && state_in == ST_FLAGS) |->
      (count_ff == BYTE_CNT_W'(DATA_BYTES - 1)))
      else $error("data phase ended early");

   // Store writes are issued only while no frame is in progress.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.write_channel || cmd.write_flags) |-> !busy)
      else $error("store write during a frame");

endmodule

`default_nettype wire

### rtl/sfe_datapath.sv
`default_nettype none

module sfe_datapath #(
   parameter int NUM_CHANNELS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sfe_pkg::cmd_type     cmd,
   input  wire logic [3:0]           req_channel,
   input  wire logic [10:0]          req_value,
   input  wire logic [7:0]           req_flag_value,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last
);
   import sfe_pkg::*;

   logic [CHAN_W-1:0]  chan_ff [NUM_CHANNELS];
   logic [7:0]         flags_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [NBITS_W-1:0] nbits_ff, nbits_in;
   logic [NEXT_W-1:0]  next_ff, next_in;
   logic               valid_ff;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff;

   logic [CHAN_W-1:0]  slot;
   logic [ACC_W-1:0]   merged;
   logic [NBITS_W-1:0] merged_bits;
   logic               do_load;

   // Channel select; channels that are not present read as zero.
   always_comb begin
      slot = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (next_ff == NEXT_W'(i)) begin
            slot = chan_ff[i];
         end
      end
   end

   always_comb begin
      do_load     = (nbits_ff < NBITS_W'(8)) && (next_ff < NEXT_W'(SLOT_COUNT));
      merged      = acc_ff;
      merged_bits = nbits_ff;
      next_in     = next_ff;
      if (do_load) begin
         merged      = acc_ff | (ACC_W'(slot) << nbits_ff);
         merged_bits = nbits_ff + NBITS_W'(CHAN_W);
         next_in     = next_ff + 1'b1;
      end
      acc_in   = merged >> 8;
      nbits_in = (merged_bits >= NBITS_W'(8)) ? merged_bits - NBITS_W'(8) : '0;
      byte_in  = merged[7:0];
      if (cmd.load_start) begin
         acc_in   = '0;
         nbits_in = '0;
         next_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_ff[i] <= (i == THROTTLE_INDEX) ? THROTTLE_MIN : CENTRE_VALUE;
         end
         flags_ff <= '0;
      end else begin
         if (cmd.write_channel) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (req_channel == SLOT_W'(i)) begin
                  chan_ff[i] <= req_value;
               end
            end
         end
         if (cmd.write_flags) begin
            flags_ff <= req_flag_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         nbits_ff <= '0;
         next_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load_start || cmd.shift_data) begin
            acc_ff   <= acc_in;
            nbits_ff <= nbits_in;
            next_ff  <= next_in;
         end
         valid_ff <= cmd.load_start || cmd.shift_data || cmd.load_flags || cmd.load_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         byte_ff <= FRAME_START;
         last_ff <= 1'b0;
      end else if (cmd.shift_data) begin
         byte_ff <= byte_in;
         last_ff <= 1'b0;
      end else if (cmd.load_flags) begin
         byte_ff <= flags_ff;
         last_ff <= 1'b0;
      end else if (cmd.load_end) begin
         byte_ff <= FRAME_END;
         last_ff <= 1'b1;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

### rtl/sbus_frame_encoder_top.sv
// The start byte of a frame appears in the cycle after the frame tick is accepted.
// A frame is 25 bytes on consecutive cycles; busy is high while all but the end byte are shown.
// A new item can be accepted in the cycle the end byte is shown, so frames can run back to back.
// Channel and flag writes produce no output; the receiver cannot stall.
// Synchronous active-high reset: channels 992, channel 2 at 128, flag byte zero, output idle.
`default_nettype none

module sbus_frame_encoder_top #(
   parameter int NUM_CHANNELS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [3:0]  req_channel,
   input  wire logic [10:0] req_value,
   input  wire logic [7:0]  req_flag_value,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);
   import sfe_pkg::*;

   // Commands from the sequencer into the channel store and bit packer.
   cmd_type cmd;

   // The controller walks the frame: start byte, 22 packed data bytes,
   // flag byte and end byte. It accepts an item only while idle.
   sfe_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .cmd      (cmd)
   );

   // The datapath holds the channel store and flag byte and packs the
   // channels least significant bit first, one output byte per cycle.
   sfe_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_channel    (req_channel),
      .req_value      (req_value),
      .req_flag_value (req_flag_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

   // The end byte is the only one that carries last.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_out_byte == FRAME_END))
      else $error("last on a byte other than the end byte");

   // When a frame starts, its start byte is on the output.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> (rsp_valid && rsp_out_byte == FRAME_START && !rsp_last))
      else $error("frame did not open with the start byte");

   // Outside a frame, the only item that can be shown is the end byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !busy) |-> rsp_last)
      else $error("stray output item while idle");

endmodule

`default_nettype wire
